@@ design/gsp_pkg.sv @@
// Shared types, constants and helper functions for the gamepad serial poller.
// Used by gsp_link_fsm, gsp_decode and gamepad_serial_poller; depends on nothing.
package gsp_pkg;

  // Field widths.
  localparam int GuardW        = 10;
  localparam int ByteIdxW      = 5;
  localparam int BitIdxW       = 3;
  localparam int FrameBytesDef = 9;
  localparam int KeptBytes     = 9;
  localparam int KeptIdxW      = $clog2(KeptBytes);
  localparam logic [GuardW-1:0] GuardReset = GuardW'(32);

  // Command and identity bytes of the poll frame.
  localparam logic [7:0] CmdAddr = 8'h01;
  localparam logic [7:0] CmdPoll = 8'h42;
  localparam logic [7:0] CmdIdle = 8'h00;
  localparam logic [7:0] IdOk    = 8'h5A;

  // Positions of the bytes within the frame.
  localparam int unsigned ByteMode = 1;
  localparam int unsigned ByteId   = 2;
  localparam int unsigned ByteBtnL = 3;
  localparam int unsigned ByteBtnH = 4;
  localparam int unsigned ByteRx   = 5;
  localparam int unsigned ByteRy   = 6;
  localparam int unsigned ByteLx   = 7;
  localparam int unsigned ByteLy   = 8;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_TRAIL = 3'd4
  } phase_e;

  typedef logic [7:0] byte_t;
  typedef byte_t [KeptBytes-1:0] frame_t;

  // Line levels produced by one tick.
  typedef struct packed {
    logic cs;
    logic clk;
    logic cmd;
    logic done;
  } line_t;

  // Decoded controller state held between frames.
  typedef struct packed {
    logic        link_ok;
    logic [7:0]  mode_byte;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } decoded_t;

  // Command byte sent at a given frame position.
  function automatic byte_t cmd_byte(input logic [ByteIdxW-1:0] idx);
    byte_t res;
    unique case (idx)
      ByteIdxW'(0): res = CmdAddr;
      ByteIdxW'(1): res = CmdPoll;
      default:      res = CmdIdle;
    endcase
    return res;
  endfunction

endpackage

@@ design/gsp_link_fsm.sv @@
// Serial link sequencer: select, clock and command timing, data sampling and
// the store of received frame bytes. Depends on gsp_pkg.
module gsp_link_fsm #(
  parameter int FRAME_BYTES = gsp_pkg::FrameBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        start_req_i,
  input  logic                        data_in_i,
  input  logic [gsp_pkg::GuardW-1:0]  guard_ticks_i,
  output gsp_pkg::line_t              line_o,
  output gsp_pkg::frame_t             frame_o
);

  gsp_pkg::phase_e                     phase_q, phase_d, work;
  logic [gsp_pkg::GuardW-1:0]          guard_q, guard_d;
  logic [gsp_pkg::ByteIdxW-1:0]        byte_q, byte_d, byte_inc;
  logic [gsp_pkg::BitIdxW-1:0]         bit_q, bit_d;
  logic [7:0]                          shift_q, shift_d, shift_v;
  gsp_pkg::frame_t                     frame_q;
  logic                                wr_en;
  logic [gsp_pkg::KeptIdxW-1:0]        wr_idx;
  gsp_pkg::byte_t                      cmd_v;
  gsp_pkg::line_t                      line;

  assign byte_inc = byte_q + gsp_pkg::ByteIdxW'(1);
  assign wr_idx   = byte_q[gsp_pkg::KeptIdxW-1:0];

  // Next state and line levels for the current tick.
  always_comb begin
    phase_d  = phase_q;
    guard_d  = guard_q;
    byte_d   = byte_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    wr_en    = 1'b0;
    line     = '{cs: 1'b1, clk: 1'b1, cmd: 1'b0, done: 1'b0};
    cmd_v    = gsp_pkg::cmd_byte(byte_q);
    shift_v  = shift_q;
    shift_v[bit_q] = shift_q[bit_q] | data_in_i;

    // A leading guard that has run out acts as the first clock-high tick.
    work = phase_q;
    if (phase_q == gsp_pkg::PH_LEAD) begin
      if (guard_q != '0) begin
        guard_d = guard_q - gsp_pkg::GuardW'(1);
        line.cs = 1'b0;
      end else begin
        work    = gsp_pkg::PH_HIGH;
        phase_d = gsp_pkg::PH_HIGH;
      end
    end

    unique case (work)
      gsp_pkg::PH_LEAD: begin
        phase_d = gsp_pkg::PH_LEAD;
      end
      gsp_pkg::PH_HIGH: begin
        line.cs  = 1'b0;
        line.cmd = cmd_v[bit_q];
        phase_d  = gsp_pkg::PH_LOW;
      end
      gsp_pkg::PH_LOW: begin
        line.cs  = 1'b0;
        line.clk = 1'b0;
        line.cmd = cmd_v[bit_q];
        if (bit_q == '1) begin
          wr_en   = (byte_q < gsp_pkg::ByteIdxW'(gsp_pkg::KeptBytes));
          shift_d = '0;
          bit_d   = '0;
          byte_d  = byte_inc;
          if (byte_inc >= gsp_pkg::ByteIdxW'(FRAME_BYTES)) begin
            phase_d = gsp_pkg::PH_TRAIL;
            guard_d = guard_ticks_i;
          end else begin
            phase_d = gsp_pkg::PH_HIGH;
          end
        end else begin
          shift_d = shift_v;
          bit_d   = bit_q + gsp_pkg::BitIdxW'(1);
          phase_d = gsp_pkg::PH_HIGH;
        end
      end
      gsp_pkg::PH_TRAIL: begin
        if (guard_q != '0) begin
          guard_d = guard_q - gsp_pkg::GuardW'(1);
        end else begin
          line.done = 1'b1;
          phase_d   = gsp_pkg::PH_IDLE;
        end
      end
      default: begin
        // Idle, and any unused code behaves as idle.
        phase_d = gsp_pkg::PH_IDLE;
        if (start_req_i) begin
          phase_d = gsp_pkg::PH_LEAD;
          guard_d = guard_ticks_i;
          byte_d  = '0;
          bit_d   = '0;
          shift_d = '0;
          line.cs = 1'b0;
        end
      end
    endcase
  end

  // Sequencer registers advance once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gsp_pkg::PH_IDLE;
      guard_q <= '0;
      byte_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      guard_q <= guard_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
    end
  end

  // Received bytes are stored as each one completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (step_i && wr_en) begin
      frame_q[wr_idx] <= shift_v;
    end
  end

  assign line_o  = line;
  assign frame_o = frame_q;

endmodule

@@ design/gsp_decode.sv @@
// Frame decoder: turns the received bytes into buttons, sticks, mode and
// link status, held until the next finished frame. Depends on gsp_pkg.
module gsp_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gsp_pkg::frame_t   frame_i,
  output gsp_pkg::decoded_t decoded_o
);

  gsp_pkg::decoded_t dec_q, dec_d;
  logic              id_ok;

  // The mode byte only counts when the identity byte matches.
  always_comb begin
    id_ok             = (frame_i[gsp_pkg::ByteId] == gsp_pkg::IdOk);
    dec_d.link_ok     = id_ok;
    dec_d.mode_byte   = id_ok ? frame_i[gsp_pkg::ByteMode] : 8'h00;
    dec_d.buttons     = {frame_i[gsp_pkg::ByteBtnH], frame_i[gsp_pkg::ByteBtnL]};
    dec_d.right_x     = frame_i[gsp_pkg::ByteRx];
    dec_d.right_y     = frame_i[gsp_pkg::ByteRy];
    dec_d.left_x      = frame_i[gsp_pkg::ByteLx];
    dec_d.left_y      = frame_i[gsp_pkg::ByteLy];
  end

  // Decoded values change only on the tick that ends a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= '0;
    end else if (load_i) begin
      dec_q <= dec_d;
    end
  end

  assign decoded_o = dec_q;

endmodule

@@ design/gamepad_serial_poller.sv @@
// Gamepad serial poller: each request is one half-bit tick of the link.
// An accepted request has its result in the output register in the next cycle.
// Throughput is one request per cycle unless the output stalls; the sequencer and the
// output register both advance on every accepted request, so the block never inserts
// bubbles. Reset clears the sequencer to idle, the frame store and the decoded state
// to zero, and loads a guard length of 32 ticks.
module gamepad_serial_poller #(
  parameter int FRAME_BYTES = gsp_pkg::FrameBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       guard_ticks_we_i,
  input  logic [gsp_pkg::GuardW-1:0] guard_ticks_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       start_req_i,
  input  logic                       data_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       chip_select_o,
  output logic                       clock_out_o,
  output logic                       command_out_o,
  output logic                       frame_done_o,
  output logic                       link_ok_o,
  output logic [7:0]                 mode_byte_o,
  output logic [15:0]                buttons_o,
  output logic [7:0]                 right_x_o,
  output logic [7:0]                 right_y_o,
  output logic [7:0]                 left_x_o,
  output logic [7:0]                 left_y_o
);

  logic [gsp_pkg::GuardW-1:0] guard_cfg_q;
  logic                       take;
  logic                       out_valid_q, out_valid_d;
  gsp_pkg::line_t             line, line_q;
  gsp_pkg::frame_t            frame;
  gsp_pkg::decoded_t          decoded;

  // Guard length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_cfg_q <= gsp_pkg::GuardReset;
    end else if (guard_ticks_we_i) begin
      guard_cfg_q <= guard_ticks_i;
    end
  end

  // A request is taken whenever the output register is free or being emptied.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  gsp_link_fsm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_link (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (take),
    .start_req_i   (start_req_i),
    .data_in_i     (data_in_i),
    .guard_ticks_i (guard_cfg_q),
    .line_o        (line),
    .frame_o       (frame)
  );

  gsp_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (take && line.done),
    .frame_i   (frame),
    .decoded_o (decoded)
  );

  // Output register for the line levels of the last accepted tick.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      line_q <= line;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chip_select_o = line_q.cs;
  assign clock_out_o   = line_q.clk;
  assign command_out_o = line_q.cmd;
  assign frame_done_o  = line_q.done;
  assign link_ok_o     = decoded.link_ok;
  assign mode_byte_o   = decoded.mode_byte;
  assign buttons_o     = decoded.buttons;
  assign right_x_o     = decoded.right_x;
  assign right_y_o     = decoded.right_y;
  assign left_x_o      = decoded.left_x;
  assign left_y_o      = decoded.left_y;

`ifndef SYNTHESIS
  // A frame ends with select already released.
  a_done_deselected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> chip_select_o)
    else $error("frame_done raised while select is active");

  // The serial clock only goes low inside a frame.
  a_clk_low_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !clock_out_o |-> !chip_select_o)
    else $error("serial clock low while select is inactive");

  // Every accepted request produces a result in the next cycle.
  a_take_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // The link status only changes on a finished frame.
  a_link_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take && line.done) |=> $stable(link_ok_o))
    else $error("link status changed outside a frame end");
`endif

endmodule
